@@ hw/rtl/psp_pkg.sv @@
// Shared constants, control word layout and microprogram of the sample player.
package psp_pkg;

    localparam int VOICES        = 16;
    localparam int SAMPLE_FRAMES = 65536;

    localparam int ADDR_W = $clog2(SAMPLE_FRAMES);
    localparam int POS_W  = 17;
    localparam int GAIN_W = 16;
    localparam int SMP_W  = 16;
    localparam int MIX_W  = 32;
    localparam int PROD_W = SMP_W + GAIN_W + 1;
    localparam int ACC_W  = 40;
    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W  = $clog2(VOICES + 1);
    localparam int Q_SHIFT = 10;

    localparam logic [16:0] LENGTH_RESET = 17'd0;
    localparam logic [15:0] GAIN_RESET   = 16'd1024;

    // input opcodes
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_PLAY  = 3'd3;
    localparam logic [2:0] OP_MUTE  = 3'd4;
    localparam logic [2:0] OP_WRITE = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_LENGTH = 2'd0;
    localparam logic [1:0] REG_LGAIN  = 2'd1;
    localparam logic [1:0] REG_RGAIN  = 2'd2;

    // datapath actions
    localparam logic [3:0] A_NONE   = 4'd0;
    localparam logic [3:0] A_ACCEPT = 4'd1;
    localparam logic [3:0] A_TINIT  = 4'd2;
    localparam logic [3:0] A_READ   = 4'd3;
    localparam logic [3:0] A_MUL    = 4'd4;
    localparam logic [3:0] A_ACC    = 4'd5;
    localparam logic [3:0] A_OUT    = 4'd6;
    localparam logic [3:0] A_CLAIM  = 4'd7;
    localparam logic [3:0] A_STOP   = 4'd8;
    localparam logic [3:0] A_PLAY   = 4'd9;
    localparam logic [3:0] A_MUTE   = 4'd10;
    localparam logic [3:0] A_WRITE  = 4'd11;

    // jump conditions
    localparam logic [2:0] C_NONE     = 3'd0;
    localparam logic [2:0] C_NOLEN    = 3'd1;
    localparam logic [2:0] C_NOTLAST  = 3'd2;
    localparam logic [2:0] C_NOSTART  = 3'd3;
    localparam logic [2:0] C_SCANMORE = 3'd4;
    localparam logic [2:0] C_OUTBUSY  = 3'd5;

    // microprogram addresses
    localparam logic [3:0] U_IDLE  = 4'd0;
    localparam logic [3:0] U_TINIT = 4'd1;
    localparam logic [3:0] U_TREAD = 4'd2;
    localparam logic [3:0] U_TMUL  = 4'd3;
    localparam logic [3:0] U_TACC  = 4'd4;
    localparam logic [3:0] U_TOUT  = 4'd5;
    localparam logic [3:0] U_START = 4'd6;
    localparam logic [3:0] U_SCAN  = 4'd7;
    localparam logic [3:0] U_STOP  = 4'd8;
    localparam logic [3:0] U_PLAY  = 4'd9;
    localparam logic [3:0] U_MUTE  = 4'd10;
    localparam logic [3:0] U_WRITE = 4'd11;

    typedef struct packed {
        logic [3:0] act;
        logic [2:0] cond;
        logic [3:0] target;
        logic       done;
    } uword_t;

    function automatic uword_t ucode(input logic [3:0] upc);
        uword_t w;
        w = '{act: A_NONE, cond: C_NONE, target: U_IDLE, done: 1'b1};
        unique case (upc)
            U_IDLE:  w = '{act: A_ACCEPT, cond: C_NONE,     target: U_IDLE,  done: 1'b1};
            U_TINIT: w = '{act: A_TINIT,  cond: C_NOLEN,    target: U_TOUT,  done: 1'b0};
            U_TREAD: w = '{act: A_READ,   cond: C_NONE,     target: U_IDLE,  done: 1'b0};
            U_TMUL:  w = '{act: A_MUL,    cond: C_NONE,     target: U_IDLE,  done: 1'b0};
            U_TACC:  w = '{act: A_ACC,    cond: C_NOTLAST,  target: U_TREAD, done: 1'b0};
            U_TOUT:  w = '{act: A_OUT,    cond: C_OUTBUSY,  target: U_TOUT,  done: 1'b1};
            U_START: w = '{act: A_NONE,   cond: C_NOSTART,  target: U_IDLE,  done: 1'b0};
            U_SCAN:  w = '{act: A_CLAIM,  cond: C_SCANMORE, target: U_SCAN,  done: 1'b1};
            U_STOP:  w = '{act: A_STOP,   cond: C_NONE,     target: U_IDLE,  done: 1'b1};
            U_PLAY:  w = '{act: A_PLAY,   cond: C_NONE,     target: U_IDLE,  done: 1'b1};
            U_MUTE:  w = '{act: A_MUTE,   cond: C_NONE,     target: U_IDLE,  done: 1'b1};
            U_WRITE: w = '{act: A_WRITE,  cond: C_NONE,     target: U_IDLE,  done: 1'b1};
            default: w = '{act: A_NONE,   cond: C_NONE,     target: U_IDLE,  done: 1'b1};
        endcase
        return w;
    endfunction

    function automatic logic [3:0] dispatch(input logic [2:0] op);
        logic [3:0] entry;
        entry = U_IDLE;
        unique case (op)
            OP_TICK:  entry = U_TINIT;
            OP_START: entry = U_START;
            OP_STOP:  entry = U_STOP;
            OP_PLAY:  entry = U_PLAY;
            OP_MUTE:  entry = U_MUTE;
            OP_WRITE: entry = U_WRITE;
            default:  entry = U_IDLE;
        endcase
        return entry;
    endfunction

endpackage

@@ hw/rtl/polyphonic_sample_player_top.sv @@
// Polyphonic sample player: microcoded voice sequencer, frame store and mixer.
//
//  channel  direction  handshake              payload
//  in       to block   in_valid / in_stall    opcode, flag_value, frame_addr, frame_left,
//                                             frame_right, mix_in_left, mix_in_right
//  out      from block out_valid / out_stall  mix_out_left, mix_out_right, voices_active
//  cfg      to block   cfg_we                 cfg_index, cfg_data
//
// A tick runs the read, multiply and accumulate steps of the microprogram loop once per
// voice slot, over one frame store port. With no sample loaded (length zero) a tick
// skips the loop and goes to output. Start scans the voice slots and claims the first
// free one unless no sample is loaded or all slots are busy. The result register holds
// an item while out_stall is high; the next item is still accepted, and a tick waits at
// its end. Reset is asynchronous; the frame store is not cleared.
module polyphonic_sample_player_top
    import psp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [2:0]               opcode,
    input  logic                     flag_value,
    input  logic [15:0]              frame_addr,
    input  logic signed [15:0]       frame_left,
    input  logic signed [15:0]       frame_right,
    input  logic signed [31:0]       mix_in_left,
    input  logic signed [31:0]       mix_in_right,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [31:0]       mix_out_left,
    output logic signed [31:0]       mix_out_right,
    output logic [4:0]               voices_active,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [16:0]              cfg_data
);

    logic [3:0]               upc_reg;
    logic [3:0]               upc_next;
    uword_t                   uw;
    logic                     cond_true;
    logic                     in_fire;

    logic [VIDX_W-1:0]        vidx_reg;
    logic [POS_W-1:0]         pos_reg [VOICES];
    logic [VOICES-1:0]        busy_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     playing_reg;
    logic                     muted_reg;

    logic [POS_W-1:0]         length_reg;
    logic [GAIN_W-1:0]        lgain_reg;
    logic [GAIN_W-1:0]        rgain_reg;

    logic                     flag_reg;
    logic [15:0]              addr_reg;
    logic [SMP_W-1:0]         fl_reg;
    logic [SMP_W-1:0]         fr_reg;
    logic signed [MIX_W-1:0]  mixl_reg;
    logic signed [MIX_W-1:0]  mixr_reg;

    logic signed [ACC_W-1:0]  accl_reg;
    logic signed [ACC_W-1:0]  accr_reg;
    logic signed [PROD_W-1:0] prodl_reg;
    logic signed [PROD_W-1:0] prodr_reg;
    logic signed [ACC_W-1:0]  terml;
    logic signed [ACC_W-1:0]  termr;

    logic                     outv_reg;
    logic signed [MIX_W-1:0]  outl_reg;
    logic signed [MIX_W-1:0]  outr_reg;
    logic [4:0]               outn_reg;

    logic [31:0]              store [SAMPLE_FRAMES];
    logic [31:0]              rd_data_reg;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [ADDR_W-1:0]        mem_raddr;

    logic                     len_zero;
    logic                     last_slot;
    logic [POS_W-1:0]         pos_cur;
    logic [POS_W-1:0]         pos_step;
    logic                     pos_live;
    logic                     pos_mapped;
    logic                     add_on;

    function automatic logic signed [MIX_W-1:0] sat(input logic signed [ACC_W-1:0] v);
        logic signed [MIX_W-1:0] r;
        r = v[MIX_W-1:0];
        if (v[ACC_W-1] && !(&v[ACC_W-1:MIX_W-1]))
        begin
            r = {1'b1, {(MIX_W-1){1'b0}}};
        end
        else if (!v[ACC_W-1] && (|v[ACC_W-1:MIX_W-1]))
        begin
            r = {1'b0, {(MIX_W-1){1'b1}}};
        end
        return r;
    endfunction

    assign in_stall      = (upc_reg != U_IDLE);
    assign in_fire       = in_valid && !in_stall;
    assign out_valid     = outv_reg;
    assign mix_out_left  = outl_reg;
    assign mix_out_right = outr_reg;
    assign voices_active = outn_reg;

    assign len_zero   = (length_reg == '0);
    assign last_slot  = (vidx_reg == VIDX_W'(VOICES - 1));
    assign pos_cur    = pos_reg[vidx_reg];
    assign pos_live   = (pos_cur < length_reg);
    assign pos_step   = pos_live ? (pos_cur + POS_W'(1)) : pos_cur;
    assign pos_mapped = (32'(pos_cur) < 32'(SAMPLE_FRAMES));
    assign add_on     = playing_reg && !muted_reg;

    assign terml = ACC_W'(prodl_reg) >>> Q_SHIFT;
    assign termr = ACC_W'(prodr_reg) >>> Q_SHIFT;

    assign uw = ucode(upc_reg);

    always_comb
    begin
        unique case (uw.cond)
            C_NONE:     cond_true = 1'b0;
            C_NOLEN:    cond_true = len_zero;
            C_NOTLAST:  cond_true = !last_slot;
            C_NOSTART:  cond_true = len_zero || (count_reg >= CNT_W'(VOICES));
            C_SCANMORE: cond_true = busy_reg[vidx_reg] && !last_slot;
            C_OUTBUSY:  cond_true = outv_reg && out_stall;
            default:    cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (uw.act == A_ACCEPT)
        begin
            upc_next = in_fire ? dispatch(opcode) : U_IDLE;
        end
        else if (cond_true)
        begin
            upc_next = uw.target;
        end
        else if (uw.done)
        begin
            upc_next = U_IDLE;
        end
        else
        begin
            upc_next = upc_reg + 4'd1;
        end
    end

    assign mem_we    = (uw.act == A_WRITE) && (32'(addr_reg) < 32'(SAMPLE_FRAMES));
    assign mem_waddr = ADDR_W'(addr_reg);
    assign mem_raddr = ADDR_W'(pos_cur);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[mem_waddr] <= {fr_reg, fl_reg};
        end
        rd_data_reg <= store[mem_raddr];
    end

    // payload, accumulator, product and output registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            flag_reg <= flag_value;
            addr_reg <= frame_addr;
            fl_reg   <= frame_left;
            fr_reg   <= frame_right;
            mixl_reg <= mix_in_left;
            mixr_reg <= mix_in_right;
        end
        if (uw.act == A_TINIT)
        begin
            accl_reg <= ACC_W'(mixl_reg);
            accr_reg <= ACC_W'(mixr_reg);
        end
        if (uw.act == A_MUL)
        begin
            prodl_reg <= PROD_W'($signed(rd_data_reg[15:0]) * $signed({1'b0, lgain_reg}));
            prodr_reg <= PROD_W'($signed(rd_data_reg[31:16]) * $signed({1'b0, rgain_reg}));
        end
        if ((uw.act == A_ACC) && busy_reg[vidx_reg] && pos_live && add_on && pos_mapped)
        begin
            accl_reg <= accl_reg + terml;
            accr_reg <= accr_reg + termr;
        end
        if ((uw.act == A_OUT) && !(outv_reg && out_stall))
        begin
            outl_reg <= sat(accl_reg);
            outr_reg <= sat(accr_reg);
            outn_reg <= 5'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg     <= U_IDLE;
            vidx_reg    <= '0;
            busy_reg    <= '0;
            count_reg   <= '0;
            playing_reg <= 1'b1;
            muted_reg   <= 1'b0;
            length_reg  <= LENGTH_RESET;
            lgain_reg   <= GAIN_RESET;
            rgain_reg   <= GAIN_RESET;
            outv_reg    <= 1'b0;
            for (int i = 0; i < VOICES; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            upc_reg <= upc_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LENGTH: length_reg <= cfg_data;
                    REG_LGAIN:  lgain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_RGAIN:  rgain_reg  <= cfg_data[GAIN_W-1:0];
                    default:    ;
                endcase
            end

            if ((uw.act == A_OUT) && !(outv_reg && out_stall))
            begin
                outv_reg <= 1'b1;
            end
            else if (outv_reg && !out_stall)
            begin
                outv_reg <= 1'b0;
            end

            unique case (uw.act)
                A_ACCEPT:
                begin
                    vidx_reg <= '0;
                end
                A_ACC:
                begin
                    if (busy_reg[vidx_reg])
                    begin
                        if (pos_step < length_reg)
                        begin
                            pos_reg[vidx_reg] <= pos_step;
                        end
                        else
                        begin
                            pos_reg[vidx_reg]  <= '0;
                            busy_reg[vidx_reg] <= 1'b0;
                            if (count_reg != '0)
                            begin
                                count_reg <= count_reg - CNT_W'(1);
                            end
                        end
                    end
                    vidx_reg <= vidx_reg + VIDX_W'(1);
                end
                A_CLAIM:
                begin
                    if (!busy_reg[vidx_reg])
                    begin
                        busy_reg[vidx_reg] <= 1'b1;
                        pos_reg[vidx_reg]  <= '0;
                        count_reg          <= count_reg + CNT_W'(1);
                    end
                    vidx_reg <= vidx_reg + VIDX_W'(1);
                end
                A_STOP:
                begin
                    if (!len_zero)
                    begin
                        busy_reg  <= '0;
                        count_reg <= '0;
                        for (int i = 0; i < VOICES; i++)
                        begin
                            pos_reg[i] <= '0;
                        end
                    end
                end
                A_PLAY:
                begin
                    if (!len_zero)
                    begin
                        playing_reg <= flag_reg;
                    end
                end
                A_MUTE:
                begin
                    if (!len_zero)
                    begin
                        muted_reg <= flag_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
